### hdl/nmea_rmc_pkg.sv
// ----------------------------------------------------------------------------
// nmea_rmc_pkg
// shared types and character constants for the rmc sentence checker
// ----------------------------------------------------------------------------
package nmea_rmc_pkg;

  // checksum field tracking, one-hot
  typedef enum logic [3:0] {
    PH_BEFORE_STAR = 4'b0001,
    PH_DIGIT_HI    = 4'b0010,
    PH_DIGIT_LO    = 4'b0100,
    PH_DONE        = 4'b1000
  } sum_phase_t;

  // one verdict beat
  typedef struct packed {
    logic       is_rmc;
    logic       checksum_ok;
    logic       fix_valid;
    logic       accepted;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [4:0] local_hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic       too_long;
  } result_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  localparam logic [15:0] FIX_PAIR = {CH_COMMA, CH_UP_A};

  localparam int PREFIX_LEN = 6;
  localparam logic [0:PREFIX_LEN-1][7:0] RMC_PREFIX = {
    CH_DOLLAR, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43
  };

  // time field hhmmss occupies character offsets 7 to 12
  localparam int TIME_FIRST = 7;
  localparam int TIME_LAST  = 12;
  localparam int TIME_DIGITS = 6;

  localparam logic [4:0] ZONE_RESET = 5'd8;
  localparam logic [1:0] ADDR_ZONE  = 2'd0;

  // two decimal digits to a value
  function automatic logic [6:0] dec2(input logic [3:0] tens, input logic [3:0] ones);
    dec2 = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
  endfunction

  // value below 131 reduced mod 24 by three compare-subtract steps
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    mod24 = t[4:0];
  endfunction

endpackage

### hdl/nmea_rmc_check_and_time.sv
// ----------------------------------------------------------------------------
// nmea_rmc_check_and_time
// checks rmc sentences character by character and reports local time
// ----------------------------------------------------------------------------
// output: the verdict beat is registered in the output register, or in the skid entry if the output is stalled
// throughput: one character per cycle while in_stall is low, set by the single per-character state
//   update; a two-entry output buffer (register plus skid) absorbs stalls
// reset: synchronous active-low rst_n clears line state, empties the output
//   buffer and sets the zone offset to 8 hours
// ----------------------------------------------------------------------------
module nmea_rmc_check_and_time #(
  parameter int MAX_LINE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // character beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_line_end,
  // verdict beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_rmc,
  output logic        out_checksum_ok,
  output logic        out_fix_valid,
  output logic        out_accepted,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic [4:0]  out_local_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  output logic        out_too_long,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nmea_rmc_pkg::*;

  // index counter saturates at MAX_LINE, so it must hold that value
  localparam int IDX_W = $clog2(MAX_LINE + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LINE);

  // ---------------------------------------------------------------- config
  logic [4:0] zone_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {27'd0, zone_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_ZONE) begin
      zone_r <= cfg_pwdata[4:0];
    end
  end

  // ---------------------------------------------------------------- line state
  logic [IDX_W-1:0] char_index_r, char_index_nxt;
  logic [7:0]       xor_sum_r, xor_sum_nxt;
  sum_phase_t       sum_phase_r, sum_phase_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic             hex_bad_r, hex_bad_nxt;
  logic             prefix_ok_r, prefix_ok_nxt;
  logic [15:0]      recent_r, recent_nxt;
  logic             fix_seen_r, fix_seen_nxt;
  logic [3:0]       time_digits_r [TIME_DIGITS];
  logic [3:0]       time_digits_nxt [TIME_DIGITS];
  logic             digits_ok_r, digits_ok_nxt;
  logic             overflow_r, overflow_nxt;

  logic             in_acc;
  logic             res_fire;
  logic             is_digit, is_hex_letter;
  logic [3:0]       hex_nib;
  logic [2:0]       slot;
  result_t          res;

  // skid buffer full means nowhere to put another verdict
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_q_r, out_q_nxt;
  result_t skid_q_r, skid_q_nxt;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign res_fire = in_acc && in_line_end;

  assign is_digit      = in_ch >= CH_ZERO && in_ch <= CH_NINE;
  assign is_hex_letter = in_ch >= CH_UP_A && in_ch <= CH_UP_F;
  assign slot          = 3'(char_index_r - IDX_W'(TIME_FIRST));

  // hex digit value, zero for anything that is not uppercase hex
  always_comb begin
    priority if (is_digit) begin
      hex_nib = 4'(in_ch - CH_ZERO);
    end else if (is_hex_letter) begin
      hex_nib = 4'(in_ch - CH_UP_A + 8'd10);
    end else begin
      hex_nib = 4'd0;
    end
  end

  // next line state after this character
  always_comb begin
    char_index_nxt = char_index_r;
    xor_sum_nxt    = xor_sum_r;
    sum_phase_nxt  = sum_phase_r;
    rx_sum_nxt     = rx_sum_r;
    hex_bad_nxt    = hex_bad_r;
    prefix_ok_nxt  = prefix_ok_r;
    recent_nxt     = {recent_r[7:0], in_ch};
    fix_seen_nxt   = fix_seen_r;
    time_digits_nxt = time_digits_r;
    digits_ok_nxt  = digits_ok_r;
    overflow_nxt   = overflow_r;

    // prefix compare over the first six characters
    if (char_index_r < IDX_W'(PREFIX_LEN) && in_ch != RMC_PREFIX[char_index_r[2:0]]) begin
      prefix_ok_nxt = 1'b0;
    end

    // leading character never enters the checksum
    if (char_index_r != '0) begin
      unique case (sum_phase_r)
        PH_BEFORE_STAR: begin
          if (in_ch == CH_STAR) begin
            sum_phase_nxt = PH_DIGIT_HI;
          end else begin
            xor_sum_nxt = xor_sum_r ^ in_ch;
          end
        end
        PH_DIGIT_HI: begin
          rx_sum_nxt    = {rx_sum_r[3:0], hex_nib};
          hex_bad_nxt   = hex_bad_r || !(is_digit || is_hex_letter);
          sum_phase_nxt = PH_DIGIT_LO;
        end
        PH_DIGIT_LO: begin
          rx_sum_nxt    = {rx_sum_r[3:0], hex_nib};
          hex_bad_nxt   = hex_bad_r || !(is_digit || is_hex_letter);
          sum_phase_nxt = PH_DONE;
        end
        PH_DONE: begin
        end
        default: begin
          sum_phase_nxt = sum_phase_r;
        end
      endcase
    end

    if (recent_r == FIX_PAIR && in_ch == CH_COMMA) begin
      fix_seen_nxt = 1'b1;
    end

    if (char_index_r >= IDX_W'(TIME_FIRST) && char_index_r <= IDX_W'(TIME_LAST)) begin
      if (is_digit) begin
        time_digits_nxt[slot] = 4'(in_ch - CH_ZERO);
      end else begin
        digits_ok_nxt = 1'b0;
      end
    end

    if (char_index_r >= IDX_MAX) begin
      overflow_nxt = 1'b1;
    end else begin
      char_index_nxt = char_index_r + 1'b1;
    end
  end

  // verdict from the state as it stands after the last character
  always_comb begin
    res.is_rmc       = prefix_ok_nxt && char_index_nxt >= IDX_W'(PREFIX_LEN);
    res.checksum_ok  = sum_phase_nxt == PH_DONE && !hex_bad_nxt && rx_sum_nxt == xor_sum_nxt;
    res.fix_valid    = fix_seen_nxt;
    res.too_long     = overflow_nxt;
    res.accepted     = res.is_rmc && res.checksum_ok && fix_seen_nxt && !overflow_nxt
                       && digits_ok_nxt && char_index_nxt >= IDX_W'(TIME_LAST + 1);
    res.computed_sum = xor_sum_nxt;
    res.received_sum = rx_sum_nxt;
    res.local_hour   = mod24({1'b0, dec2(time_digits_nxt[0], time_digits_nxt[1])}
                             + {3'b000, zone_r});
    res.minute       = dec2(time_digits_nxt[2], time_digits_nxt[3]);
    res.second       = dec2(time_digits_nxt[4], time_digits_nxt[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_index_r <= '0;
      xor_sum_r    <= '0;
      sum_phase_r  <= PH_BEFORE_STAR;
      rx_sum_r     <= '0;
      hex_bad_r    <= 1'b0;
      prefix_ok_r  <= 1'b1;
      recent_r     <= '0;
      fix_seen_r   <= 1'b0;
      digits_ok_r  <= 1'b1;
      overflow_r   <= 1'b0;
      for (int i = 0; i < TIME_DIGITS; i++) time_digits_r[i] <= '0;
    end else if (res_fire) begin
      // line done, start the next one clean
      char_index_r <= '0;
      xor_sum_r    <= '0;
      sum_phase_r  <= PH_BEFORE_STAR;
      rx_sum_r     <= '0;
      hex_bad_r    <= 1'b0;
      prefix_ok_r  <= 1'b1;
      recent_r     <= '0;
      fix_seen_r   <= 1'b0;
      digits_ok_r  <= 1'b1;
      overflow_r   <= 1'b0;
      for (int i = 0; i < TIME_DIGITS; i++) time_digits_r[i] <= '0;
    end else if (in_acc) begin
      char_index_r  <= char_index_nxt;
      xor_sum_r     <= xor_sum_nxt;
      sum_phase_r   <= sum_phase_nxt;
      rx_sum_r      <= rx_sum_nxt;
      hex_bad_r     <= hex_bad_nxt;
      prefix_ok_r   <= prefix_ok_nxt;
      recent_r      <= recent_nxt;
      fix_seen_r    <= fix_seen_nxt;
      digits_ok_r   <= digits_ok_nxt;
      overflow_r    <= overflow_nxt;
      time_digits_r <= time_digits_nxt;
    end
  end

  // ---------------------------------------------------------------- output buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_q_nxt      = out_q_r;
    skid_q_nxt     = skid_q_r;
    priority if (skid_valid_r) begin
      // input is stalled here, only drain
      if (!out_stall) begin
        out_q_nxt      = skid_q_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || !out_stall) begin
        out_q_nxt     = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_q_nxt     = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_q_r  <= out_q_nxt;
    skid_q_r <= skid_q_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_rmc       = out_q_r.is_rmc;
  assign out_checksum_ok  = out_q_r.checksum_ok;
  assign out_fix_valid    = out_q_r.fix_valid;
  assign out_accepted     = out_q_r.accepted;
  assign out_computed_sum = out_q_r.computed_sum;
  assign out_received_sum = out_q_r.received_sum;
  assign out_local_hour   = out_q_r.local_hour;
  assign out_minute       = out_q_r.minute;
  assign out_second       = out_q_r.second;
  assign out_too_long     = out_q_r.too_long;

  // ---------------------------------------------------------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    char_index_r <= IDX_MAX)
    else $error("character index past saturation");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> char_index_r == '0 && xor_sum_r == '0 && sum_phase_r == PH_BEFORE_STAR)
    else $error("line state not cleared after last character");

  a_xor_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_line_end && sum_phase_r != PH_BEFORE_STAR |=> $stable(xor_sum_r))
    else $error("checksum changed after star");

  a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_q_r.local_hour < 5'd24)
    else $error("local hour out of range");

endmodule
